// ===== rtl/crc16fc_pkg.sv =====
// Package for the CRC-16 frame checker: item and result types, constants and
// the byte-wide reflected CRC step. No dependencies.
`default_nettype none

package crc16fc_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] POLY_RESET    = 16'h8408;
    localparam logic [1:0]  HELD_FULL     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] crc_value;
        logic        check_ok;
        logic        too_short;
    } t_result;

    // Eight unrolled steps of the reflected CRC, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] crc;
        crc = crc_in;
        for (int b = 0; b < 8; b++) begin
            if (crc[0] ^ data[b]) begin
                crc = {1'b0, crc[15:1]} ^ poly;
            end else begin
                crc = {1'b0, crc[15:1]};
            end
        end
        return crc;
    endfunction

    // Inverts the CRC and swaps its two bytes.
    function automatic logic [15:0] crc_finish(input logic [15:0] crc);
        logic [15:0] inv;
        inv = ~crc;
        return {inv[7:0], inv[15:8]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/crc16fc_in_stage.sv =====
// Input register of the CRC-16 frame checker. Holds one byte transfer until
// the core takes it. Depends on crc16fc_pkg.
`default_nettype none

module crc16fc_in_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [7:0]             i_data_byte,
    input  wire                    i_last,
    input  wire                    i_take,
    output logic                   o_valid,
    output crc16fc_pkg::t_in_item  o_item
);

    logic                  r_valid;
    crc16fc_pkg::t_in_item r_item;
    logic                  accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte <= i_data_byte;
            r_item.last      <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/crc16fc_core.sv =====
// Frame state of the CRC-16 frame checker: running and lagging CRCs, the two
// held bytes and the frame result. Depends on crc16fc_pkg.
`default_nettype none

module crc16fc_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [15:0]            i_polynomial,
    input  wire                    i_valid,
    input  crc16fc_pkg::t_in_item  i_item,
    input  wire                    i_out_ready,
    output logic                   o_take,
    output logic                   o_res_valid,
    output crc16fc_pkg::t_result   o_result
);

    logic [15:0] r_running;
    logic [15:0] r_lagging;
    logic [1:0]  r_count;
    logic [7:0]  r_held0;
    logic [7:0]  r_held1;

    logic [15:0] n_running;
    logic [15:0] n_lagging;
    logic [1:0]  n_count;
    logic [15:0] expect_crc;
    logic        short_frame;

    assign o_take      = i_valid && (!i_item.last || i_out_ready);
    assign o_res_valid = o_take && i_item.last;

    assign n_running = crc16fc_pkg::crc_byte(r_running, i_item.data_byte, i_polynomial);
    assign n_lagging = (r_count == crc16fc_pkg::HELD_FULL)
                     ? crc16fc_pkg::crc_byte(r_lagging, r_held0, i_polynomial)
                     : r_lagging;
    assign n_count   = (r_count == crc16fc_pkg::HELD_FULL) ? r_count : r_count + 2'd1;

    assign short_frame = (n_count != crc16fc_pkg::HELD_FULL);
    assign expect_crc  = crc16fc_pkg::crc_finish(n_lagging);

    assign o_result.crc_value = crc16fc_pkg::crc_finish(n_running);
    assign o_result.too_short = short_frame;
    assign o_result.check_ok  = !short_frame
                              && (r_held1 == expect_crc[7:0])
                              && (i_item.data_byte == expect_crc[15:8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= crc16fc_pkg::CRC_INIT;
            r_lagging <= crc16fc_pkg::CRC_INIT;
            r_count   <= 2'd0;
        end else if (o_take) begin
            if (i_item.last) begin
                r_running <= crc16fc_pkg::CRC_INIT;
                r_lagging <= crc16fc_pkg::CRC_INIT;
                r_count   <= 2'd0;
            end else begin
                r_running <= n_running;
                r_lagging <= n_lagging;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_held0 <= r_held1;
            r_held1 <= i_item.data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/crc16fc_out_stage.sv =====
// Output register of the CRC-16 frame checker. Holds one frame result until
// the receiver takes it. Depends on crc16fc_pkg.
`default_nettype none

module crc16fc_out_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  crc16fc_pkg::t_result  i_result,
    output logic                  o_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output crc16fc_pkg::t_result  o_result
);

    logic                 r_valid;
    crc16fc_pkg::t_result r_result;

    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// ===== rtl/crc16_frame_check.sv =====
// Top level of the CRC-16 frame checker: polynomial register, input stage,
// frame core and output stage. Depends on crc16fc_pkg and the crc16fc modules.
//
// Bytes of a frame arrive one per transfer on the input channel, with i_last
// marking the final byte. For each frame one result leaves on the output
// channel: the inverted, byte-swapped CRC of all bytes, a flag that the final
// two bytes match the CRC of the bytes before them (low byte first), and a
// flag for frames shorter than two bytes. Bytes other than the last give no
// result.
// A byte transfer lands in the input register; the core runs both eight-bit
// CRC updates on the registered byte and, on a last byte, writes the output
// register. One byte is taken every cycle except while a last byte waits;
// the combinational eight-bit CRC update sets that rate. Non-last bytes keep
// flowing while a result is stalled; a last byte waits in the input register
// until the output register is free. Reset clears both CRCs to 0xFFFF,
// empties the frame and both registers and sets the polynomial to 0x8408.
// The user must write the polynomial through i_cfg_wr_en and i_cfg_wr_data
// only while no frame is in flight; the block itself does not enforce this.
`default_nettype none

module crc16_frame_check (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [15:0] i_cfg_wr_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [15:0] o_crc_value,
    output logic        o_check_ok,
    output logic        o_too_short
);

    logic [15:0]           r_polynomial;
    logic                  in_valid_q;
    crc16fc_pkg::t_in_item in_item_q;
    logic                  take;
    logic                  res_valid;
    logic                  out_ready;
    crc16fc_pkg::t_result  core_result;
    crc16fc_pkg::t_result  out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polynomial <= crc16fc_pkg::POLY_RESET;
        end else if (i_cfg_wr_en) begin
            r_polynomial <= i_cfg_wr_data;
        end
    end

    crc16fc_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_take      (take),
        .o_valid     (in_valid_q),
        .o_item      (in_item_q)
    );

    crc16fc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_polynomial (r_polynomial),
        .i_valid      (in_valid_q),
        .i_item       (in_item_q),
        .i_out_ready  (out_ready),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .o_result     (core_result)
    );

    crc16fc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_result    (core_result),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_crc_value = out_result.crc_value;
    assign o_check_ok  = out_result.check_ok;
    assign o_too_short = out_result.too_short;

endmodule

`default_nettype wire

// ===== rtl/crc16fc_checker.sv =====
// Port-level checks for the CRC-16 frame checker, bound to its top level.
// Depends on crc16_frame_check only through the bind below.
`default_nettype none

module crc16fc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [15:0] o_crc_value,
    input wire        o_check_ok,
    input wire        o_too_short
);

    // A stalled result keeps its valid and its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_crc_value)
            && $stable(o_check_ok) && $stable(o_too_short))
        else $error("stalled result changed");

    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall present after reset");

    // The input only backs up behind a stalled result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_too_short |-> !o_check_ok)
        else $error("short frame reported as passing");

endmodule

bind crc16_frame_check crc16fc_checker u_crc16fc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_crc_value (o_crc_value),
    .o_check_ok  (o_check_ok),
    .o_too_short (o_too_short)
);

`default_nettype wire
